// File: src/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants, codes and handshake types of the sorted list table.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  // Default list depth
  localparam int CAPACITY_DEF = 16;

  // Fixed field widths
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Operation kinds
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new request
    logic compare;    // build the insert and remove masks
    logic execute;    // apply the operation and emit its result
    logic dump_step;  // emit the head entry and rotate the list
  } slt_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_dump;    // held request is a dump
    logic list_empty; // no entries held
    logic dump_last;  // current dump step emits the tail entry
  } slt_stat_t;

endpackage

`default_nettype wire

// File: src/slt_ctrl.sv
// ----------------------------------------------------------------------------
// slt_ctrl
// Controller: sequences the compare and execute steps of each request, and the dump steps of a dump.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire slt_pkg::slt_stat_t stat,
  output logic                   busy,
  output slt_pkg::slt_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_EXEC = 4'b0100,
    S_DUMP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Work out the next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (stat.is_dump && !stat.list_empty) state_nxt = S_DUMP;
        else state_nxt = S_IDLE;
      end
      S_DUMP: if (stat.dump_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Drive commands from the current state
  assign busy           = (state_r != S_IDLE);
  assign cmd.load       = (state_r == S_IDLE) && start;
  assign cmd.compare    = (state_r == S_CMP);
  assign cmd.execute    = (state_r == S_EXEC);
  assign cmd.dump_step  = (state_r == S_DUMP);

endmodule

`default_nettype wire

// File: src/slt_dpath.sv
// ----------------------------------------------------------------------------
// slt_dpath
// Datapath: entry register file with parallel compare, shift and rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_dpath #(
  parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire slt_pkg::slt_cmd_t                   cmd,
  input  wire logic [slt_pkg::KIND_W-1:0]          in_kind,
  input  wire logic signed [slt_pkg::DATA_W-1:0]   in_value,
  output slt_pkg::slt_stat_t                       stat,
  output logic                                     out_valid,
  output logic [slt_pkg::STAT_W-1:0]               out_status,
  output logic signed [slt_pkg::DATA_W-1:0]        out_entry,
  output logic [slt_pkg::COUNT_W-1:0]              out_count,
  output logic                                     out_last
);

  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int DW     = slt_pkg::DATA_W;

  logic [slt_pkg::KIND_W-1:0] op_r;
  logic [DW-1:0]              val_r;
  logic [DW-1:0]              entries_r   [CAPACITY];
  logic [DW-1:0]              entries_nxt [CAPACITY];
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [FILL_W-1:0]          dump_cnt_r, dump_cnt_nxt;
  logic [CAPACITY-1:0]        ins_mask_r, ins_mask_nxt;
  logic [CAPACITY-1:0]        rem_mask_r, rem_mask_nxt;

  logic                       ov_nxt, ol_nxt;
  logic [slt_pkg::STAT_W-1:0] os_nxt;
  logic [DW-1:0]              oe_nxt;
  logic                       list_full, found;

  assign list_full = (fill_r == FILL_W'(CAPACITY));
  assign found     = rem_mask_r[CAPACITY-1];

  assign stat.is_dump    = (op_r == slt_pkg::KIND_DUMP);
  assign stat.list_empty = (fill_r == '0);
  assign stat.dump_last  = ((dump_cnt_r + FILL_W'(1)) == fill_r);

  // Build masks: slots at or past the insert point, and at or past the match
  always_comb begin
    logic run_g, run_e, in_list;
    run_g = 1'b0;
    run_e = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      in_list = (FILL_W'(i) < fill_r);
      run_g   = run_g | !in_list | ($signed(entries_r[i]) > $signed(val_r));
      run_e   = run_e | (in_list && (entries_r[i] == val_r));
      ins_mask_nxt[i] = (op_r == slt_pkg::KIND_PUSH) ? 1'b1 : run_g;
      rem_mask_nxt[i] = run_e;
    end
  end

  // Apply the operation, rotate during dump, and form the result
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) entries_nxt[i] = entries_r[i];
    fill_nxt     = fill_r;
    dump_cnt_nxt = dump_cnt_r;
    ov_nxt       = 1'b0;
    os_nxt       = slt_pkg::ST_OK;
    oe_nxt       = val_r;
    ol_nxt       = 1'b1;

    if (cmd.execute) begin
      ov_nxt       = 1'b1;
      dump_cnt_nxt = '0;
      case (op_r)
        slt_pkg::KIND_PUSH, slt_pkg::KIND_INSERT: begin
          if (list_full) begin
            os_nxt = slt_pkg::ST_FULL;
          end else begin
            // open a slot at the first set mask bit
            for (int i = 0; i < CAPACITY; i++) begin
              if (ins_mask_r[i]) begin
                if (i == 0)                 entries_nxt[i] = val_r;
                else if (!ins_mask_r[i-1])  entries_nxt[i] = val_r;
                else                        entries_nxt[i] = entries_r[i-1];
              end
            end
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
        slt_pkg::KIND_REMOVE: begin
          if (fill_r == '0) begin
            os_nxt = slt_pkg::ST_EMPTY;
          end else if (!found) begin
            os_nxt = slt_pkg::ST_NOTFOUND;
          end else begin
            // close the gap left by the matching entry
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (rem_mask_r[i]) entries_nxt[i] = entries_r[i+1];
            end
            fill_nxt = fill_r - FILL_W'(1);
          end
        end
        slt_pkg::KIND_CLEAR: begin
          os_nxt   = (fill_r == '0) ? slt_pkg::ST_EMPTY : slt_pkg::ST_OK;
          oe_nxt   = '0;
          fill_nxt = '0;
        end
        slt_pkg::KIND_DUMP: begin
          // only an empty list answers here; otherwise the dump steps follow
          ov_nxt = (fill_r == '0);
          os_nxt = slt_pkg::ST_EMPTY;
          oe_nxt = '0;
        end
        default: begin
          os_nxt = slt_pkg::ST_OK;
        end
      endcase
    end else if (cmd.dump_step) begin
      ov_nxt       = 1'b1;
      oe_nxt       = entries_r[0];
      ol_nxt       = stat.dump_last;
      dump_cnt_nxt = dump_cnt_r + FILL_W'(1);
      // rotate the held entries by one towards the head
      for (int i = 0; i < CAPACITY; i++) begin
        if (FILL_W'(i + 1) < fill_r && i < CAPACITY - 1) begin
          entries_nxt[i] = entries_r[(i + 1) % CAPACITY];
        end else if (FILL_W'(i + 1) == fill_r) begin
          entries_nxt[i] = entries_r[0];
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      out_valid <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_kind;
      val_r <= in_value;
    end
    if (cmd.compare) begin
      ins_mask_r <= ins_mask_nxt;
      rem_mask_r <= rem_mask_nxt;
    end
    for (int i = 0; i < CAPACITY; i++) entries_r[i] <= entries_nxt[i];
    dump_cnt_r <= dump_cnt_nxt;
    out_status <= os_nxt;
    out_entry  <= oe_nxt;
    out_count  <= slt_pkg::COUNT_W'(fill_nxt);
    out_last   <= ol_nxt;
  end

endmodule

`default_nettype wire

// File: src/sorted_list_table_core.sv
// ----------------------------------------------------------------------------
// sorted_list_table_core
// Bounded ordered list of signed 32-bit values with push, insert, remove,
// clear and dump requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Push, insert, remove,
// clear and unused kinds give one result. After acceptance the compare state
// registers the masks from the parallel compare over all slots. The execute
// state then loads the shifted list and the output register together. busy
// drops in the result cycle, so the next request can be taken while the result
// is on the ports, but not before the previous one has reached the output
// register. A dump of n entries gives n results on consecutive cycles, one
// from each dump state that follows the execute state. busy stays up through
// the compare, execute and dump states. The list rotates by one slot per
// result and ends in its original order. Results are marked by out_valid for
// exactly one cycle and cannot be held off, so the receiver must take every
// strobe. The list needs no clearing pass after reset.
`default_nettype none

module sorted_list_table_core #(
  parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [slt_pkg::KIND_W-1:0]        in_kind,
  input  wire logic signed [slt_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  output logic [slt_pkg::STAT_W-1:0]             out_status,
  output logic signed [slt_pkg::DATA_W-1:0]      out_entry,
  output logic [slt_pkg::COUNT_W-1:0]            out_count,
  output logic                                   out_last
);

  slt_pkg::slt_cmd_t  cmd;
  slt_pkg::slt_stat_t stat;

  slt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  slt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_entry  (out_entry),
    .out_count  (out_count),
    .out_last   (out_last)
  );

  // A dump result that is not the tail is followed at once by the next one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("dump results not contiguous");

  // An accepted request keeps the block busy for the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // A full rejection reports a full list
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == slt_pkg::ST_FULL |->
      (CAPACITY > 31 || out_count == slt_pkg::COUNT_W'(CAPACITY)))
    else $error("full status with list not full");

endmodule

`default_nettype wire
